[sv/fps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the funnel path smoother.
package fps_pkg;
    localparam int FUNNEL_DEPTH_DEF = 32;
    localparam int COORD_BITS_DEF   = 24;
    localparam int MAX_RESULTS      = 32;
    localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_LEFT  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_GOAL  = 2'd3
    } t_action;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;
endpackage

[sv/fps_if.sv]
`timescale 1ns / 1ps
// Request channels: vertex input and path output.
interface fps_in_if #(parameter int COORD_BITS = fps_pkg::COORD_BITS_DEF);
    import fps_pkg::*;
    logic                          valid;
    logic                          ready;
    t_action                       action;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_z;
    modport source (output valid, action, pos_x, pos_z, input ready);
    modport sink   (input valid, action, pos_x, pos_z, output ready);
endinterface

interface fps_out_if #(parameter int COORD_BITS = fps_pkg::COORD_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  path_x;
    logic signed [COORD_BITS-1:0]  path_z;
    logic                          last_of_run;
    logic                          overflow;
    modport source (output valid, path_x, path_z, last_of_run, overflow, input ready);
    modport sink   (input valid, path_x, path_z, last_of_run, overflow, output ready);
endinterface

[sv/fps_store.sv]
`timescale 1ns / 1ps
// Funnel deque storage: one write port, one registered read port.
module fps_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/fps_turn.sv]
`timescale 1ns / 1ps
// Three-stage turn test: sign of u.x*w.z - u.z*w.x, u = +/-(b - a), w = +/-(v - a).
module fps_turn #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS-1:0] i_ax, i_az,
    input  logic signed [COORD_BITS-1:0] i_bx, i_bz,
    input  logic signed [COORD_BITS-1:0] i_vx, i_vz,
    input  logic                         i_adir,
    input  logic                         i_bneg,
    output fps_pkg::t_sign               o_sign
);
    import fps_pkg::*;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] n_ux, n_uz, n_wx, n_wz;
    logic signed [DW-1:0] r_ux, r_uz, r_wx, r_wz;
    logic signed [PW-1:0] r_p, r_q;
    logic signed [PW:0]   w_diff;

    always_comb begin
        if (i_adir) begin
            n_ux = DW'(i_bx) - DW'(i_ax);
            n_uz = DW'(i_bz) - DW'(i_az);
        end else begin
            n_ux = DW'(i_ax) - DW'(i_bx);
            n_uz = DW'(i_az) - DW'(i_bz);
        end
        if (i_bneg) begin
            n_wx = DW'(i_ax) - DW'(i_vx);
            n_wz = DW'(i_az) - DW'(i_vz);
        end else begin
            n_wx = DW'(i_vx) - DW'(i_ax);
            n_wz = DW'(i_vz) - DW'(i_az);
        end
    end

    assign w_diff = (PW+1)'(r_p) - (PW+1)'(r_q);

    always_ff @(posedge i_clk) begin
        r_ux <= n_ux;
        r_uz <= n_uz;
        r_wx <= n_wx;
        r_wz <= n_wz;
        r_p  <= r_ux * r_wz;
        r_q  <= r_uz * r_wx;
        o_sign.neg  <= w_diff[PW];
        o_sign.zero <= (w_diff == '0);
    end
endmodule

[sv/funnel_path_smoother.sv]
`timescale 1ns / 1ps
// Funnel path smoother top level: sequencer around the deque store.
//
//  channel    dir  payload
//  i_vertex   in   action, pos_x, pos_z
//  o_path     out  path_x, path_z, last_of_run, overflow
//
// Each funnel step (pop test) runs two store reads, a 3-stage turn unit and
// the decision; a start item writes the store and emits, a push writes one slot.
// One item at a time; input ready only while the sequencer is idle.
// i_rst_n clears pointers, count and flags; store contents stay undefined.
// A full output register stalls the sequencer at the next emitted vertex.
module funnel_path_smoother #(
    parameter int FUNNEL_DEPTH = fps_pkg::FUNNEL_DEPTH_DEF,
    parameter int COORD_BITS   = fps_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fps_in_if.sink    i_vertex,
    fps_out_if.source o_path
);
    import fps_pkg::*;
    localparam int AW = $clog2(FUNNEL_DEPTH);
    localparam int NW = $clog2(FUNNEL_DEPTH + 1);
    localparam int EW = 2 * COORD_BITS;
    localparam logic [NW-1:0] DEPTH_N = NW'(FUNNEL_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_L_TOP, S_R_TOP, S_G_INIT, S_G_TOP,
        S_RD_A, S_RD_B, S_CAP_B, S_TURN, S_DECIDE, S_PUSH, S_EMIT, S_FLUSH
    } t_state;

    t_state r_state, r_ret;
    t_action r_act;
    logic signed [COORD_BITS-1:0] r_vx, r_vz, r_ax, r_az, r_bx, r_bz, r_ex, r_ez;
    logic [AW-1:0] r_front, r_apex, r_sa, r_sb, r_i;
    logic [NW-1:0] r_cnt;
    logic          r_flag, r_adir, r_bneg, r_down, r_first;
    logic [1:0]    r_wait;
    logic [RES_CNT_W-1:0] r_ncnt;
    logic          r_pend_v, r_pend_f;
    logic signed [COORD_BITS-1:0] r_pend_x, r_pend_z;
    logic          r_ov, r_olast, r_oflag;
    logic signed [COORD_BITS-1:0] r_ox, r_oz;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr, w_fdec, w_dist;
    logic [EW-1:0] w_rdata;
    t_sign         w_sign;
    logic          w_out_free;
    logic          w_load;
    logic [AW-1:0] w_last;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [NW-1:0] pos);
        logic [NW:0] s;
        s = (NW+1)'(front) + (NW+1)'(pos);
        if (s >= (NW+1)'(FUNNEL_DEPTH)) begin
            s = s - (NW+1)'(FUNNEL_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    fps_store #(.DEPTH(FUNNEL_DEPTH), .WIDTH(EW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_vx, r_vz}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fps_turn #(.COORD_BITS(COORD_BITS)) u_turn (
        .i_clk  (i_clk),
        .i_ax   (r_ax), .i_az (r_az),
        .i_bx   (r_bx), .i_bz (r_bz),
        .i_vx   (r_vx), .i_vz (r_vz),
        .i_adir (r_adir),
        .i_bneg (r_bneg),
        .o_sign (w_sign)
    );

    assign w_fdec = (r_front == '0) ? AW'(FUNNEL_DEPTH - 1) : r_front - AW'(1);
    assign w_dist = (r_apex >= r_front) ? r_apex - r_front
                                        : AW'((NW+1)'(r_apex) + (NW+1)'(FUNNEL_DEPTH)
                                              - (NW+1)'(r_front));
    assign w_last = AW'(r_cnt - NW'(1));
    assign w_out_free = !r_ov || o_path.ready;
    // output register loaded from the pending request this cycle
    assign w_load = r_pend_v && w_out_free &&
                    ((r_state == S_EMIT && r_ncnt != RES_CNT_W'(MAX_RESULTS)) ||
                     r_state == S_FLUSH);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = slot(r_front, r_cnt);
        if (r_state == S_START) begin
            w_we    = 1'b1;
            w_waddr = '0;
        end else if (r_state == S_PUSH && r_cnt < DEPTH_N) begin
            w_we    = 1'b1;
            w_waddr = (r_act == ACT_LEFT) ? w_fdec : slot(r_front, r_cnt);
        end
        w_raddr = (r_state == S_RD_B) ? r_sb : r_sa;
    end

    assign i_vertex.ready     = (r_state == S_IDLE);
    assign o_path.valid       = r_ov;
    assign o_path.path_x      = r_ox;
    assign o_path.path_z      = r_oz;
    assign o_path.last_of_run = r_olast;
    assign o_path.overflow    = r_oflag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_front  <= '0;
            r_apex   <= '0;
            r_cnt    <= '0;
            r_flag   <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (o_path.ready && !w_load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_vertex.valid) begin
                        r_act  <= i_vertex.action;
                        r_vx   <= i_vertex.pos_x;
                        r_vz   <= i_vertex.pos_z;
                        r_ncnt <= '0;
                        unique case (i_vertex.action)
                            ACT_START: r_state <= S_START;
                            ACT_LEFT:  r_state <= S_L_TOP;
                            ACT_RIGHT: r_state <= S_R_TOP;
                            ACT_GOAL:  r_state <= S_G_INIT;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_START: begin
                    r_front <= '0;
                    r_apex  <= '0;
                    r_cnt   <= NW'(1);
                    r_flag  <= 1'b0;
                    r_ex    <= r_vx;
                    r_ez    <= r_vz;
                    r_ret   <= S_FLUSH;
                    r_state <= S_EMIT;
                end
                S_L_TOP: begin
                    r_sa   <= r_front;
                    r_sb   <= slot(r_front, NW'(1));
                    r_adir <= (r_apex == r_front);
                    r_bneg <= 1'b1;
                    if (r_cnt == '0) r_state <= S_FLUSH;
                    else if (r_cnt == NW'(1)) r_state <= S_PUSH;
                    else r_state <= S_RD_A;
                end
                S_R_TOP: begin
                    r_sa   <= slot(r_front, r_cnt - NW'(1));
                    r_sb   <= slot(r_front, r_cnt - NW'(2));
                    r_adir <= (r_apex == slot(r_front, r_cnt - NW'(1)));
                    r_bneg <= 1'b0;
                    if (r_cnt == '0) r_state <= S_FLUSH;
                    else if (r_cnt == NW'(1)) r_state <= S_PUSH;
                    else r_state <= S_RD_A;
                end
                S_G_INIT: begin
                    r_i     <= (w_dist > w_last) ? w_last : w_dist;
                    r_first <= 1'b1;
                    r_down  <= 1'b1;
                    r_adir  <= 1'b1;
                    r_bneg  <= 1'b0;
                    r_ex    <= r_vx;
                    r_ez    <= r_vz;
                    r_ret   <= S_FLUSH;
                    r_state <= (r_cnt == '0) ? S_EMIT : S_G_TOP;
                end
                S_G_TOP: begin
                    r_sa <= slot(r_front, NW'(r_i));
                    r_ex <= r_vx;
                    r_ez <= r_vz;
                    if (r_down) begin
                        r_sb <= slot(r_front, NW'(r_i) - NW'(1));
                        if (r_i != '0) begin
                            r_state <= S_RD_A;
                        end else if (r_first) begin
                            r_down <= 1'b0;
                        end else begin
                            r_ret   <= S_FLUSH;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_sb <= slot(r_front, NW'(r_i) + NW'(1));
                        if (r_i != w_last) begin
                            r_state <= S_RD_A;
                        end else begin
                            r_ret   <= S_FLUSH;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RD_A: r_state <= S_RD_B;
                S_RD_B: begin
                    r_ax    <= w_rdata[EW-1:COORD_BITS];
                    r_az    <= w_rdata[COORD_BITS-1:0];
                    r_state <= S_CAP_B;
                end
                S_CAP_B: begin
                    r_bx    <= w_rdata[EW-1:COORD_BITS];
                    r_bz    <= w_rdata[COORD_BITS-1:0];
                    r_wait  <= '0;
                    r_state <= S_TURN;
                end
                S_TURN: begin
                    r_wait <= r_wait + 2'd1;
                    if (r_wait == 2'd2) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_ex <= r_bx;
                    r_ez <= r_bz;
                    unique case (r_act)
                        ACT_LEFT, ACT_RIGHT: begin
                            if (w_sign.neg || w_sign.zero) begin
                                r_state <= S_PUSH;
                            end else begin
                                r_cnt <= r_cnt - NW'(1);
                                if (r_act == ACT_LEFT) r_front <= r_sb;
                                r_ret <= (r_act == ACT_LEFT) ? S_L_TOP : S_R_TOP;
                                if (r_apex == r_sa) begin
                                    r_apex  <= r_sb;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= (r_act == ACT_LEFT) ? S_L_TOP : S_R_TOP;
                                end
                            end
                        end
                        default: begin
                            r_ret <= S_G_TOP;
                            if (r_down) begin
                                if (!w_sign.neg) begin
                                    r_i     <= r_i - AW'(1);
                                    r_first <= 1'b0;
                                    r_state <= S_EMIT;
                                end else begin
                                    if (r_first) r_down <= 1'b0;
                                    else r_i <= '0;
                                    r_first <= 1'b0;
                                    r_state <= S_G_TOP;
                                end
                            end else begin
                                if (w_sign.neg || w_sign.zero) begin
                                    r_i     <= r_i + AW'(1);
                                    r_state <= S_EMIT;
                                end else begin
                                    r_i     <= w_last;
                                    r_state <= S_G_TOP;
                                end
                            end
                        end
                    endcase
                end
                S_PUSH: begin
                    if (r_cnt >= DEPTH_N) begin
                        r_flag <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + NW'(1);
                        if (r_act == ACT_LEFT) r_front <= w_fdec;
                    end
                    r_state <= S_FLUSH;
                end
                S_EMIT: begin
                    if (r_ncnt == RES_CNT_W'(MAX_RESULTS)) begin
                        r_state <= r_ret;
                    end else if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_ov    <= 1'b1;
                            r_ox    <= r_pend_x;
                            r_oz    <= r_pend_z;
                            r_oflag <= r_pend_f;
                            r_olast <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        r_pend_x <= r_ex;
                        r_pend_z <= r_ez;
                        r_pend_f <= r_flag;
                        r_ncnt   <= r_ncnt + RES_CNT_W'(1);
                        r_state  <= r_ret;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_ov     <= 1'b1;
                        r_ox     <= r_pend_x;
                        r_oz     <= r_pend_z;
                        r_oflag  <= r_pend_f;
                        r_olast  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
